// ----- hdl/ovrring_pkg.sv -----
package ovrring_pkg;

   // ring geometry; the field widths of the item follow from the depth
   localparam int RING_DEPTH = 8192;
   localparam int POS_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = POS_W + 1;

   // operation codes
   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_TX_REQ  = 2'd1,
      OP_TX_DONE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   // one request beat
   typedef struct packed {
      op_type             op;
      logic [7:0]         data_byte;
      logic [POS_W-1:0]   read_index;
   } req_type;

   // one response beat
   typedef struct packed {
      logic [7:0]         read_data;
      logic               chunk_sent;
      logic [POS_W-1:0]   chunk_start;
      logic [CNT_W-1:0]   chunk_len;
      logic [CNT_W-1:0]   fill_level;
      logic               overwrote;
   } rsp_type;

endpackage

// ----- hdl/overwrite_ring_with_chunk_drain.sv -----
// Transmit byte ring with overwrite of the oldest byte and chunked drain.
// Request channel: a beat is taken at a rising edge with start high and busy
// low; req_data carries the operation (write byte, transmit request,
// transmit complete, read byte), the byte to append and the position to read.
// Response channel: every request beat yields exactly one response beat,
// shown on rsp_data for a single cycle with rsp_valid high, in the cycle after
// the request edge. The receiver cannot stall; it must take the beat then.
// Throughput is one request per cycle, busy stays low: each operation costs
// one write or one read of the byte memory (one write port at the tail, one
// registered read port) plus a pointer update.
// A transmit request hands out the run from the head up to the wrap point or
// the fill level, whichever is smaller, and holds further chunks off until a
// transmit complete. A write into a full ring replaces the oldest byte.
// Synchronous reset empties the ring (head, tail and fill level zero) and
// marks the endpoint ready; the byte memory is not cleared, so reading a
// position that was never written returns an undefined byte.
module overwrite_ring_with_chunk_drain
   import ovrring_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   // byte memory
   logic [7:0]       ring_mem [RING_DEPTH];
   logic [7:0]       rd_byte_ff;

   // pointers and status
   logic [POS_W-1:0] head_ff, head_in;
   logic [POS_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ready_ff, ready_in;

   // response registers
   logic             valid_ff;
   logic             was_read_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             ring_full;
   logic [CNT_W-1:0] room;
   logic [CNT_W-1:0] chunk_len;

   // one beat a cycle, never held off
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign ring_full = (count_ff == CNT_W'(RING_DEPTH));
   assign room      = CNT_W'(RING_DEPTH) - {1'b0, head_ff};
   assign chunk_len = (count_ff < room) ? count_ff : room;

   // next pointer state and response fields
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ready_in = ready_ff;
      rsp_in   = '0;
      if (accept) begin
         unique case (req_data.op)
            OP_WRITE: begin
               tail_in = tail_ff + POS_W'(1);
               if (ring_full) begin
                  head_in          = tail_ff + POS_W'(1);
                  rsp_in.overwrote = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_TX_REQ: begin
               if (ready_ff && (count_ff != '0)) begin
                  ready_in           = 1'b0;
                  rsp_in.chunk_sent  = 1'b1;
                  rsp_in.chunk_start = head_ff;
                  rsp_in.chunk_len   = chunk_len;
                  count_in           = count_ff - chunk_len;
                  head_in            = head_ff + chunk_len[POS_W-1:0];
               end
            end
            OP_TX_DONE: begin
               ready_in = 1'b1;
            end
            OP_READ: begin
            end
            default: begin
            end
         endcase
      end
      rsp_in.fill_level = count_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         ready_ff    <= 1'b1;
         valid_ff    <= 1'b0;
         was_read_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         ready_ff    <= ready_in;
         valid_ff    <= accept;
         was_read_ff <= accept && (req_data.op == OP_READ);
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // byte memory: write at the tail, registered read at the request index
   always_ff @(posedge clock) begin
      if (accept && (req_data.op == OP_WRITE)) begin
         ring_mem[tail_ff] <= req_data.data_byte;
      end
      rd_byte_ff <= ring_mem[req_data.read_index];
   end

   // response outputs
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_data = was_read_ff ? rd_byte_ff : 8'd0;
   end
   assign rsp_valid = valid_ff;

   // pointer distance always matches the fill level modulo the depth
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (tail_ff - head_ff) == count_ff[POS_W-1:0])
      else $error("ring pointers disagree with fill level");

   // fill level never exceeds the depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("fill level beyond ring depth");

   // a chunk is non-empty and stops at the wrap point
   a_chunk_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_sent |->
         (rsp_data.chunk_len != '0) &&
         (({1'b0, rsp_data.chunk_start} + (CNT_W+1)'(rsp_data.chunk_len))
            <= (CNT_W+1)'(RING_DEPTH)))
      else $error("chunk crosses the wrap point");

   // an overwrite only happens with the ring full
   a_ovw_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overwrote |-> rsp_data.fill_level == CNT_W'(RING_DEPTH))
      else $error("overwrite reported on a ring that is not full");

   // a chunk leaves the endpoint not ready until completion
   a_chunk_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_sent |-> !ready_ff || $past(accept && 
         (req_data.op == OP_TX_DONE)))
      else $error("endpoint still ready after a chunk");

endmodule

// ----- test/tb_overwrite_ring_with_chunk_drain.sv -----
module tb_overwrite_ring_with_chunk_drain;
   timeunit 1ns;
   timeprecision 1ps;
   import ovrring_pkg::*;

   localparam int RANDOM_ITEMS = 1050;
   localparam int MAX_SHOWN    = 10;
   localparam int DRAIN_CYCLES = 4;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // predicted ring state
   logic [7:0]       shadow_bytes [RING_DEPTH];
   logic [POS_W-1:0] shadow_head;
   logic [POS_W-1:0] shadow_tail;
   int               shadow_fill;
   bit               shadow_ready;

   rsp_type ring_rsp_q [$];
   int      fail_count;
   int      writes_issued;
   int      calm_left;

   overwrite_ring_with_chunk_drain u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #30ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // advance the predicted ring by one operation and return its response
   function automatic rsp_type ring_step(input req_type r);
      rsp_type o;
      int      room;
      int      len;
      o = '0;
      case (r.op)
         OP_WRITE: begin
            shadow_bytes[shadow_tail] = r.data_byte;
            shadow_tail = shadow_tail + POS_W'(1);
            shadow_fill++;
            // full ring: oldest byte is lost, head follows tail
            if (shadow_fill > RING_DEPTH) begin
               shadow_fill = RING_DEPTH;
               shadow_head = shadow_tail;
               o.overwrote = 1'b1;
            end
         end
         OP_TX_REQ: begin
            // chunk runs from head up to the fill level or the wrap point
            if (shadow_ready && shadow_fill > 0) begin
               room = RING_DEPTH - int'(shadow_head);
               len  = (shadow_fill < room) ? shadow_fill : room;
               shadow_ready  = 1'b0;
               o.chunk_sent  = 1'b1;
               o.chunk_start = shadow_head;
               o.chunk_len   = CNT_W'(len);
               shadow_fill  -= len;
               shadow_head   = shadow_head + POS_W'(len);
            end
         end
         OP_TX_DONE: begin
            shadow_ready = 1'b1;
         end
         default: begin
            o.read_data = shadow_bytes[r.read_index];
         end
      endcase
      o.fill_level = CNT_W'(shadow_fill);
      return o;
   endfunction

   // check the response beat of this cycle, then log the request beat taken
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (ring_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("unexpected response beat at %0t", $realtime);
            end else begin
               want = ring_rsp_q.pop_front();
               if (rsp_data.read_data   !== want.read_data   ||
                   rsp_data.chunk_sent  !== want.chunk_sent  ||
                   rsp_data.chunk_start !== want.chunk_start ||
                   rsp_data.chunk_len   !== want.chunk_len   ||
                   rsp_data.fill_level  !== want.fill_level  ||
                   rsp_data.overwrote   !== want.overwrote) begin
                  fail_count++;
                  if (fail_count <= MAX_SHOWN) begin
                     $display("mismatch at %0t: exp rd=%h sent=%b start=%0d",
                              $realtime, want.read_data, want.chunk_sent,
                              want.chunk_start,
                              "   len=%0d fill=%0d ow=%b",
                              want.chunk_len, want.fill_level, want.overwrote);
                     $display("   got rd=%h sent=%b start=%0d len=%0d fill=%0d ow=%b",
                              rsp_data.read_data, rsp_data.chunk_sent,
                              rsp_data.chunk_start, rsp_data.chunk_len,
                              rsp_data.fill_level, rsp_data.overwrote);
                  end
               end
            end
         end
         if (start && !busy)
            ring_rsp_q.push_back(ring_step(req_data));
      end
   end

   // idle gap before a beat: mostly none or short, a few long, some calm runs
   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 150);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 96)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // a ring position that has already been written
   function automatic logic [POS_W-1:0] pick_index();
      int hi;
      hi = (writes_issued >= RING_DEPTH) ? RING_DEPTH - 1 : writes_issued - 1;
      return POS_W'($urandom_range(0, hi));
   endfunction

   // present one beat and wait until it is taken
   task automatic send_op(input op_type op, input logic [7:0] data,
                          input logic [POS_W-1:0] idx);
      req_type item;
      int      gap;
      item.op         = op;
      item.data_byte  = data;
      item.read_index = idx;
      gap = pick_gap();
      if (op == OP_WRITE)
         writes_issued++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [POS_W-1:0] rand_pos();
      return POS_W'($urandom_range(0, RING_DEPTH - 1));
   endfunction

   // transmit on empty ring, completion while ready, chunk gating
   task automatic test_tx_corners();
      send_op(OP_TX_REQ, 8'hFF, '1);
      send_op(OP_TX_DONE, 8'h00, '0);
      send_op(OP_WRITE, 8'h00, '1);
      send_op(OP_WRITE, 8'hFF, '0);
      send_op(OP_WRITE, 8'hA5, rand_pos());
      send_op(OP_WRITE, 8'h5A, rand_pos());
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
      send_op(OP_WRITE, 8'h3C, '0);
      // not ready: no chunk
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
      send_op(OP_TX_DONE, rand_byte(), '1);
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
      send_op(OP_TX_DONE, rand_byte(), rand_pos());
      send_op(OP_TX_DONE, rand_byte(), rand_pos());
      // ready but drained
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
   endtask

   // reads of written positions, unused fields set
   task automatic test_read_back();
      send_op(OP_READ, 8'hFF, '0);
      send_op(OP_READ, 8'h00, 13'd1);
      send_op(OP_READ, 8'hFF, 13'd2);
      send_op(OP_READ, rand_byte(), 13'd3);
      send_op(OP_READ, rand_byte(), 13'd4);
      send_op(OP_WRITE, 8'h81, '1);
      send_op(OP_READ, rand_byte(), 13'd5);
   endtask

   // fill the whole ring, overwrite the oldest, drain across the wrap point
   task automatic test_fill_overwrite();
      repeat (RING_DEPTH + 9) send_op(OP_WRITE, rand_byte(), rand_pos());
      send_op(OP_READ, rand_byte(), POS_W'(RING_DEPTH - 1));
      send_op(OP_READ, rand_byte(), '0);
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
      // chunk bytes in flight get overwritten
      repeat (5) send_op(OP_WRITE, rand_byte(), rand_pos());
      send_op(OP_READ, rand_byte(), pick_index());
      send_op(OP_TX_DONE, rand_byte(), rand_pos());
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
      send_op(OP_TX_DONE, rand_byte(), rand_pos());
      send_op(OP_TX_REQ, rand_byte(), rand_pos());
      send_op(OP_TX_DONE, rand_byte(), rand_pos());
   endtask

   // write bursts drained by transmit/complete pairs, with some noise
   task automatic test_random_traffic();
      int     counted;
      int     n;
      op_type op;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 80) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                             : $urandom_range(1, 24);
            repeat (n) send_op(OP_WRITE, rand_byte(), rand_pos());
            counted += n;
            n = $urandom_range(0, 3);
            repeat (n) send_op(OP_READ, rand_byte(), pick_index());
            counted += n;
            send_op(OP_TX_REQ, rand_byte(), rand_pos());
            n = $urandom_range(0, 4);
            repeat (n) send_op(OP_WRITE, rand_byte(), rand_pos());
            counted += n + 2;
            send_op(OP_TX_DONE, rand_byte(), rand_pos());
         end else begin
            op = op_type'($urandom_range(0, 3));
            send_op(op, rand_byte(), (op == OP_READ) ? pick_index() : rand_pos());
            counted++;
         end
      end
   endtask

   // main sequence
   initial begin
      int i;
      start         <= 1'b0;
      reset         <= 1'b1;
      req_data      <= '0;
      fail_count    = 0;
      writes_issued = 0;
      calm_left     = 0;
      shadow_head   = '0;
      shadow_tail   = '0;
      shadow_fill   = 0;
      shadow_ready  = 1'b1;
      for (i = 0; i < RING_DEPTH; i++)
         shadow_bytes[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_tx_corners();
      test_read_back();
      test_fill_overwrite();
      test_random_traffic();

      // let every outstanding response arrive
      start <= 1'b0;
      while (ring_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ring_rsp_q.size() != 0)
         fail_count++;
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
